/* hw/rtl/skt_pkg.sv */
package skt_pkg;

   localparam int DEPTH        = 16;
   localparam int KEY_BITS     = 64;
   localparam int PAYLOAD_BITS = 32;
   localparam int IDX_W        = $clog2(DEPTH);
   localparam int CNT_W        = $clog2(DEPTH + 1);
   localparam int SRCH_W       = CNT_W + 2;
   localparam int OP_W         = 3;
   localparam int POS_W        = 4;
   localparam int STATUS_W     = 2;
   localparam int FPOS_W       = 4;

   localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
   localparam logic [OP_W-1:0] OP_DELETE    = 3'd1;
   localparam logic [OP_W-1:0] OP_FIND      = 3'd2;
   localparam logic [OP_W-1:0] OP_READ      = 3'd3;
   localparam logic [OP_W-1:0] OP_OVERWRITE = 3'd4;

   localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_RANGE    = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]         op;
      logic [KEY_BITS-1:0]     key;
      logic [PAYLOAD_BITS-1:0] payload;
      logic [POS_W-1:0]        position;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [FPOS_W-1:0]       found_position;
      logic [KEY_BITS-1:0]     read_key;
      logic [PAYLOAD_BITS-1:0] read_payload;
      logic [CNT_W-1:0]        entry_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic exec;
      logic step;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_find;
      logic search_end;
   } stat_type;

endpackage

/* hw/rtl/sorted_key_table_top.sv */
// insert, delete, read, overwrite: the request is registered on the accepting edge, the EXEC
// state then registers the result and its strobe; no new item is taken before then
// find: EXEC registers the compare vectors and the search range, then SEARCH runs the steps
// (one compare per cycle, a miss takes a step of its own to see the range empty)
// busy stays high until the result is issued; the receiver cannot stall
// reset clears the entry count and the controller; entries themselves are not cleared
module sorted_key_table_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  skt_pkg::req_type req_item,
   output logic             rsp_valid,
   output skt_pkg::rsp_type rsp_item
);

   skt_pkg::cmd_type  cmd;
   skt_pkg::stat_type stat;

   skt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   skt_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_item  (req_item),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

/* hw/rtl/skt_ctrl.sv */
module skt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  skt_pkg::stat_type stat,
   output skt_pkg::cmd_type  cmd,
   output logic              busy
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_EXEC   = 3'b010,
      S_SEARCH = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = stat.is_find ? S_SEARCH : S_IDLE;
         end
         S_SEARCH: begin
            if (stat.search_end) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy     = (state_ff != S_IDLE);
   assign cmd.load = (state_ff == S_IDLE) && start;
   assign cmd.exec = (state_ff == S_EXEC);
   assign cmd.step = (state_ff == S_SEARCH);

endmodule

/* hw/rtl/skt_datapath.sv */
module skt_datapath (
   input  logic             clock,
   input  logic             reset,
   input  skt_pkg::cmd_type cmd,
   input  skt_pkg::req_type req_item,
   output skt_pkg::stat_type stat,
   output logic             rsp_valid,
   output skt_pkg::rsp_type rsp_item
);

   localparam int DEPTH  = skt_pkg::DEPTH;
   localparam int IDX_W  = skt_pkg::IDX_W;
   localparam int CNT_W  = skt_pkg::CNT_W;
   localparam int SRCH_W = skt_pkg::SRCH_W;
   localparam int KW     = skt_pkg::KEY_BITS;
   localparam int PW     = skt_pkg::PAYLOAD_BITS;
   localparam int POS_W  = skt_pkg::POS_W;
   localparam int FPOS_W = skt_pkg::FPOS_W;

   skt_pkg::req_type req_ff;
   skt_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [KW-1:0]    keys_ff [DEPTH];
   logic [KW-1:0]    keys_in [DEPTH];
   logic [PW-1:0]    pays_ff [DEPTH];
   logic [PW-1:0]    pays_in [DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;

   logic [DEPTH-1:0] lt_ff, lt_in;
   logic [DEPTH-1:0] eq_ff, eq_in;
   logic signed [SRCH_W-1:0] lo_ff, lo_in;
   logic signed [SRCH_W-1:0] hi_ff, hi_in;

   logic             pos_ok;
   logic [IDX_W-1:0] pos_idx;
   logic [IDX_W-1:0] ins_idx;
   logic             full;

   logic signed [SRCH_W-1:0] mid_sum;
   logic signed [SRCH_W-1:0] mid;
   logic [IDX_W-1:0]         mid_idx;
   logic                     miss;
   logic                     hit;
   logic                     key_below;
   logic [IDX_W-1:0]         low_idx;

   // parallel compare of the request key against every entry
   always_comb begin
      for (int j = 0; j < DEPTH; j++) begin
         lt_in[j] = req_ff.key < keys_ff[j];
         eq_in[j] = req_ff.key == keys_ff[j];
      end
   end

   assign pos_ok  = (CNT_W + POS_W)'(req_ff.position) < (CNT_W + POS_W)'(count_ff);
   assign pos_idx = IDX_W'(req_ff.position);
   assign full    = (count_ff == CNT_W'(DEPTH));

   // insert lands just above the last entry not greater than the key
   always_comb begin
      ins_idx = '0;
      for (int j = 0; j < DEPTH; j++) begin
         if ((CNT_W'(j) < count_ff) && !lt_in[j]) ins_idx = IDX_W'(j + 1);
      end
   end

   // one binary search step per cycle on the registered compare vectors
   assign mid_sum   = lo_ff + hi_ff;
   assign mid       = mid_sum >>> 1;
   assign mid_idx   = mid[IDX_W-1:0];
   assign miss      = lo_ff > hi_ff;
   assign hit       = !miss && eq_ff[mid_idx];
   assign key_below = !lt_ff[mid_idx] && !eq_ff[mid_idx];

   // walk down to the lowest index of the run of equal keys
   always_comb begin
      low_idx = '0;
      for (int j = 0; j < DEPTH; j++) begin
         if ((IDX_W'(j) < mid_idx) && !eq_ff[j]) low_idx = IDX_W'(j + 1);
      end
   end

   assign stat.is_find    = (req_ff.op == skt_pkg::OP_FIND);
   assign stat.search_end = miss || hit;

   always_comb begin
      keys_in      = keys_ff;
      pays_in      = pays_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;

      if (cmd.exec) begin
         lo_in        = '0;
         hi_in        = SRCH_W'(count_ff) - SRCH_W'(1);
         rsp_valid_in = !stat.is_find;
         rsp_in.status = skt_pkg::STAT_OK;
         unique case (req_ff.op)
            skt_pkg::OP_INSERT: begin
               if (full) begin
                  rsp_in.status = skt_pkg::STAT_FULL;
               end else begin
                  for (int j = 1; j < DEPTH; j++) begin
                     if ((IDX_W'(j) > ins_idx) && (CNT_W'(j) <= count_ff)) begin
                        keys_in[j] = keys_ff[j-1];
                        pays_in[j] = pays_ff[j-1];
                     end
                  end
                  keys_in[ins_idx]      = req_ff.key;
                  pays_in[ins_idx]      = req_ff.payload;
                  count_in              = count_ff + CNT_W'(1);
                  rsp_in.found_position = FPOS_W'(ins_idx);
               end
            end
            skt_pkg::OP_DELETE: begin
               if (!pos_ok) begin
                  rsp_in.status = skt_pkg::STAT_RANGE;
               end else begin
                  // entries at and above the count hold nothing readable
                  for (int j = 0; j < DEPTH - 1; j++) begin
                     if (IDX_W'(j) >= pos_idx) begin
                        keys_in[j] = keys_ff[j+1];
                        pays_in[j] = pays_ff[j+1];
                     end
                  end
                  count_in = count_ff - CNT_W'(1);
               end
            end
            skt_pkg::OP_READ: begin
               if (!pos_ok) begin
                  rsp_in.status = skt_pkg::STAT_RANGE;
               end else begin
                  rsp_in.read_key     = keys_ff[pos_idx];
                  rsp_in.read_payload = pays_ff[pos_idx];
               end
            end
            skt_pkg::OP_OVERWRITE: begin
               if (!pos_ok) begin
                  rsp_in.status = skt_pkg::STAT_RANGE;
               end else begin
                  keys_in[pos_idx] = req_ff.key;
                  pays_in[pos_idx] = req_ff.payload;
               end
            end
            default: begin
            end
         endcase
         rsp_in.entry_count = count_in;
      end else if (cmd.step) begin
         if (miss) begin
            rsp_valid_in  = 1'b1;
            rsp_in.status = skt_pkg::STAT_NOTFOUND;
         end else if (hit) begin
            rsp_valid_in          = 1'b1;
            rsp_in.status         = skt_pkg::STAT_OK;
            rsp_in.found_position = FPOS_W'(low_idx);
            rsp_in.read_key       = req_ff.key;
            rsp_in.read_payload   = pays_ff[low_idx];
         end else if (key_below) begin
            lo_in = mid + SRCH_W'(1);
         end else begin
            hi_in = mid - SRCH_W'(1);
         end
         rsp_in.entry_count = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_item;
      if (cmd.exec) begin
         lt_ff <= lt_in;
         eq_ff <= eq_in;
      end
      keys_ff <= keys_in;
      pays_ff <= pays_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

/* test/sorted_key_table_top_tb.sv */
`timescale 1ns / 1ps

module sorted_key_table_top_tb;

   localparam int RANDOM_ITEMS = 1550;
   localparam int RUN_LIMIT    = 400000;
   localparam int DRAIN_CYCLES = 20;
   localparam int POOL_SIZE    = 16;

   // op codes the block leaves unused
   localparam logic [skt_pkg::OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [skt_pkg::OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

   typedef struct {
      skt_pkg::req_type req;
      bit               typed;
      skt_pkg::rsp_type want;
   } script_row_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   skt_pkg::req_type req_item;
   logic             rsp_valid;
   skt_pkg::rsp_type rsp_item;

   // shadow of the table contents
   logic [skt_pkg::KEY_BITS-1:0]     table_keys[skt_pkg::DEPTH];
   logic [skt_pkg::PAYLOAD_BITS-1:0] table_payloads[skt_pkg::DEPTH];
   int                               table_fill;

   skt_pkg::rsp_type             pending_results[$];
   script_row_type               script_rows[$];
   logic [skt_pkg::KEY_BITS-1:0] key_pool[POOL_SIZE];

   int error_count;
   int cycle_count;
   int idle_free_left;
   int mode_left;
   bit drain_mode;

   sorted_key_table_top DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // applies one item to the shadow table and returns the result it causes
   function automatic skt_pkg::rsp_type apply_table_op(skt_pkg::req_type r);
      skt_pkg::rsp_type res;
      int      p;
      int      q;
      int      lo;
      int      hi;
      int      mid;
      bit      hit;
      res = '0;
      res.status = skt_pkg::STAT_OK;
      case (r.op)
         skt_pkg::OP_INSERT: begin
            if (table_fill >= skt_pkg::DEPTH) begin
               res.status = skt_pkg::STAT_FULL;
            end else begin
               p = table_fill;
               while (p > 0 && r.key < table_keys[p-1]) begin
                  table_keys[p]     = table_keys[p-1];
                  table_payloads[p] = table_payloads[p-1];
                  p--;
               end
               table_keys[p]      = r.key;
               table_payloads[p]  = r.payload;
               table_fill++;
               res.found_position = skt_pkg::FPOS_W'(p);
            end
         end
         skt_pkg::OP_DELETE: begin
            if (r.position >= table_fill) begin
               res.status = skt_pkg::STAT_RANGE;
            end else begin
               for (q = r.position; q + 1 < table_fill; q++) begin
                  table_keys[q]     = table_keys[q+1];
                  table_payloads[q] = table_payloads[q+1];
               end
               table_fill--;
            end
         end
         skt_pkg::OP_FIND: begin
            lo  = 0;
            hi  = table_fill - 1;
            hit = 1'b0;
            // binary search on the table as it stands, then walk down to the first equal key
            while (lo <= hi && !hit) begin
               mid = (lo + hi) / 2;
               if (table_keys[mid] == r.key) begin
                  while (mid > 0 && table_keys[mid-1] == r.key) mid--;
                  hit                = 1'b1;
                  res.found_position = skt_pkg::FPOS_W'(mid);
                  res.read_key       = table_keys[mid];
                  res.read_payload   = table_payloads[mid];
               end else if (table_keys[mid] < r.key) begin
                  lo = mid + 1;
               end else begin
                  hi = mid - 1;
               end
            end
            if (!hit) res.status = skt_pkg::STAT_NOTFOUND;
         end
         skt_pkg::OP_READ: begin
            if (r.position >= table_fill) begin
               res.status = skt_pkg::STAT_RANGE;
            end else begin
               res.read_key     = table_keys[r.position];
               res.read_payload = table_payloads[r.position];
            end
         end
         skt_pkg::OP_OVERWRITE: begin
            if (r.position >= table_fill) begin
               res.status = skt_pkg::STAT_RANGE;
            end else begin
               table_keys[r.position]     = r.key;
               table_payloads[r.position] = r.payload;
            end
         end
         default: ;
      endcase
      res.entry_count = skt_pkg::CNT_W'(table_fill);
      return res;
   endfunction

   function automatic skt_pkg::rsp_type result_of(
         logic [skt_pkg::STATUS_W-1:0] st, logic [skt_pkg::FPOS_W-1:0] fpos,
         logic [skt_pkg::KEY_BITS-1:0] k, logic [skt_pkg::PAYLOAD_BITS-1:0] pl,
         logic [skt_pkg::CNT_W-1:0] cnt);
      skt_pkg::rsp_type res;
      res.status         = st;
      res.found_position = fpos;
      res.read_key       = k;
      res.read_payload   = pl;
      res.entry_count    = cnt;
      return res;
   endfunction

   function automatic void add_row(logic [skt_pkg::OP_W-1:0] op,
                                   logic [skt_pkg::KEY_BITS-1:0] k,
                                   logic [skt_pkg::PAYLOAD_BITS-1:0] pl,
                                   logic [skt_pkg::POS_W-1:0] pos,
                                   bit typed, skt_pkg::rsp_type want);
      script_row_type row;
      row.req.op       = op;
      row.req.key      = k;
      row.req.payload  = pl;
      row.req.position = pos;
      row.typed        = typed;
      row.want         = want;
      script_rows.push_back(row);
   endfunction

   function automatic logic [skt_pkg::KEY_BITS-1:0] pick_key();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 35) return key_pool[$urandom_range(0, POOL_SIZE-1)];
      if (roll < 55 && table_fill > 0) return table_keys[$urandom_range(0, table_fill-1)];
      if (roll < 65) begin
         case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return 64'd1;
            default: return {1'b1, 63'd0};
         endcase
      end
      return {32'($urandom), 32'($urandom)};
   endfunction

   function automatic skt_pkg::req_type random_item();
      skt_pkg::req_type r;
      int      roll;
      if (mode_left == 0) begin
         drain_mode = ~drain_mode;
         mode_left  = $urandom_range(40, 160);
      end
      mode_left--;
      roll = $urandom_range(0, 99);
      if (drain_mode) begin
         if (roll < 12)      r.op = skt_pkg::OP_INSERT;
         else if (roll < 45) r.op = skt_pkg::OP_DELETE;
         else if (roll < 68) r.op = skt_pkg::OP_FIND;
         else if (roll < 82) r.op = skt_pkg::OP_READ;
         else if (roll < 98) r.op = skt_pkg::OP_OVERWRITE;
         else r.op = skt_pkg::OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      end else begin
         if (roll < 40)      r.op = skt_pkg::OP_INSERT;
         else if (roll < 50) r.op = skt_pkg::OP_DELETE;
         else if (roll < 70) r.op = skt_pkg::OP_FIND;
         else if (roll < 82) r.op = skt_pkg::OP_READ;
         else if (roll < 98) r.op = skt_pkg::OP_OVERWRITE;
         else r.op = skt_pkg::OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      end
      if (table_fill > 0 && $urandom_range(0, 99) < 85)
         r.position = skt_pkg::POS_W'($urandom_range(0, table_fill-1));
      else
         r.position = skt_pkg::POS_W'($urandom_range(0, 15));
      r.key     = pick_key();
      r.payload = $urandom;
      // overwrites mostly update the payload only, so the order mostly holds
      if (r.op == skt_pkg::OP_OVERWRITE && r.position < table_fill &&
          $urandom_range(0, 99) < 70)
         r.key = table_keys[r.position];
      if (r.op == skt_pkg::OP_FIND && table_fill > 0 && $urandom_range(0, 1) == 1)
         r.key = table_keys[$urandom_range(0, table_fill-1)];
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      if (idle_free_left > 0) begin
         idle_free_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         idle_free_left = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   // entered and left just after a falling edge
   task automatic issue(input skt_pkg::req_type r, input bit typed,
                        input skt_pkg::rsp_type want);
      int               gap;
      skt_pkg::rsp_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      predicted = apply_table_op(r);
      pending_results.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   task automatic log_failure(input string what, input skt_pkg::rsp_type want,
                              input skt_pkg::rsp_type got);
      error_count++;
      if (error_count <= 10)
         $display({"%0t %s: want st=%0d pos=%0d key=%h pl=%h cnt=%0d,",
                   " got st=%0d pos=%0d key=%h pl=%h cnt=%0d"},
                  $realtime, what, want.status, want.found_position, want.read_key,
                  want.read_payload, want.entry_count, got.status, got.found_position,
                  got.read_key, got.read_payload, got.entry_count);
   endtask

   always @(posedge clock) begin
      skt_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_results.size() == 0) begin
            log_failure("unexpected result", '0, rsp_item);
         end else begin
            want = pending_results.pop_front();
            if (rsp_item.status !== want.status ||
                rsp_item.found_position !== want.found_position ||
                rsp_item.read_key !== want.read_key ||
                rsp_item.read_payload !== want.read_payload ||
                rsp_item.entry_count !== want.entry_count)
               log_failure("result mismatch", want, rsp_item);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int               counted;
      skt_pkg::req_type r;
      reset          = 1'b1;
      start          = 1'b0;
      req_item       = '0;
      table_fill     = 0;
      error_count    = 0;
      cycle_count    = 0;
      idle_free_left = 0;
      mode_left      = 0;
      drain_mode     = 1'b1;

      // empty table: every position is out of range, nothing to find
      add_row(skt_pkg::OP_READ, '0, '0, 4'd0, 1'b1,
              result_of(skt_pkg::STAT_RANGE, 4'd0, '0, '0, 5'd0));
      add_row(skt_pkg::OP_DELETE, '0, '0, 4'd15, 1'b1,
              result_of(skt_pkg::STAT_RANGE, 4'd0, '0, '0, 5'd0));
      add_row(skt_pkg::OP_OVERWRITE, '1, '1, 4'd0, 1'b1,
              result_of(skt_pkg::STAT_RANGE, 4'd0, '0, '0, 5'd0));
      add_row(skt_pkg::OP_FIND, '1, '0, 4'd0, 1'b1,
              result_of(skt_pkg::STAT_NOTFOUND, 4'd0, '0, '0, 5'd0));
      add_row(OP_UNUSED_FIRST, '1, '1, 4'd15, 1'b1,
              result_of(skt_pkg::STAT_OK, 4'd0, '0, '0, 5'd0));
      // key extremes, the smaller one lands in front
      add_row(skt_pkg::OP_INSERT, '1, '1, 4'd0, 1'b1,
              result_of(skt_pkg::STAT_OK, 4'd0, '0, '0, 5'd1));
      add_row(skt_pkg::OP_INSERT, '0, '0, 4'd15, 1'b1,
              result_of(skt_pkg::STAT_OK, 4'd0, '0, '0, 5'd2));
      add_row(skt_pkg::OP_READ, '0, '0, 4'd1, 1'b1,
              result_of(skt_pkg::STAT_OK, 4'd0, '1, '1, 5'd2));
      add_row(skt_pkg::OP_FIND, '1, '0, 4'd0, 1'b1,
              result_of(skt_pkg::STAT_OK, 4'd1, '1, '1, 5'd2));
      // equal keys: insert goes after, find reports the lowest
      add_row(skt_pkg::OP_INSERT, '1, 32'h0000_1234, 4'd0, 1'b0, '0);
      add_row(skt_pkg::OP_FIND, '1, '0, 4'd0, 1'b0, '0);
      // overwrite that breaks the order, then search the unsorted table
      add_row(skt_pkg::OP_OVERWRITE, '0, 32'h5555_aaaa, 4'd2, 1'b0, '0);
      add_row(skt_pkg::OP_FIND, '0, '0, 4'd0, 1'b0, '0);
      for (int i = 0; i < skt_pkg::DEPTH - 3; i++)
         add_row(skt_pkg::OP_INSERT, 64'h0102_0304_0506_0708 * (i + 1), 32'(i), 4'd0,
                 1'b0, '0);
      add_row(skt_pkg::OP_INSERT, 64'd1, '1, 4'd0, 1'b1,
              result_of(skt_pkg::STAT_FULL, 4'd0, '0, '0, 5'd16));
      add_row(skt_pkg::OP_DELETE, '0, '0, 4'd15, 1'b1,
              result_of(skt_pkg::STAT_OK, 4'd0, '0, '0, 5'd15));

      for (int i = 0; i < POOL_SIZE; i++)
         key_pool[i] = {32'($urandom), 32'($urandom)} &
                       ({skt_pkg::KEY_BITS{1'b1}} << (8 * $urandom_range(0, 7)));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script_rows[i])
         issue(script_rows[i].req, script_rows[i].typed, script_rows[i].want);

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         r = random_item();
         issue(r, 1'b0, '0);
         if (r.op <= skt_pkg::OP_OVERWRITE) counted++;
      end
      start <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
